// ----- rtl/core/tlg_pkg.sv -----
package tlg_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_GAP     = 2'd1;

  // Layout modes. Codes outside this list behave as an empty layout.
  localparam logic [2:0] MODE_GRID   = 3'd0;
  localparam logic [2:0] MODE_QUEUE  = 3'd1;
  localparam logic [2:0] MODE_STACK  = 3'd2;
  localparam logic [2:0] MODE_FULL   = 3'd3;
  localparam logic [2:0] MODE_SINGLE = 3'd4;

  localparam int unsigned COORD_W = 16;

endpackage

// ----- rtl/core/tlg_div.sv -----
module tlg_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic signed [NUM_W-1:0] quo_o,
  output logic signed [NUM_W-1:0] rem_o,
  output logic                    done_o
);

  localparam int MAG_W = NUM_W - 1;
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [MAG_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [NUM_W-1:0] quo_pos;
  logic [NUM_W-1:0] rem_pos;

  assign num_mag = num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
  assign trial   = {rem_q, acc_q[MAG_W-1]};
  assign diff    = trial - {1'b0, den_q};
  assign fits    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      acc_q <= num_mag[MAG_W-1:0];
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc_q <= {acc_q[MAG_W-2:0], fits};
    end
  end

  // Truncation toward zero: quotient and remainder take the dividend's sign.
  assign quo_pos = {1'b0, acc_q};
  assign rem_pos = {{(NUM_W-DEN_W){1'b0}}, rem_q};
  assign quo_o   = neg_q ? $signed(~quo_pos + 1'b1) : $signed(quo_pos);
  assign rem_o   = neg_q ? $signed(~rem_pos + 1'b1) : $signed(rem_pos);
  assign done_o  = done_q;

endmodule

// ----- rtl/core/tile_layout_geometry_generator.sv -----
// Tile layout geometry generator. Each accepted request (frame rectangle, view count, cap,
// layout mode) produces one tile rectangle per placed view, in placement order, with
// last_tile marking the final one; requests that place nothing produce no transaction.
// The user must set border width and tile gap through the write port only while the block
// is idle; the block itself does not enforce this. The block takes one request at a time.
// Full, single and one-view requests pass a setup state and then emit their tiles. Queue and
// stack requests add one division, grid requests a column and row search and two divisions.
// Each division runs on a single shared restoring divider at one quotient bit per cycle:
// it loads the operands, produces the quotient bits and hands back the result. Tiles leave
// through an output register, so the next request is accepted while the last tile waits.
module tile_layout_geometry_generator #(
  parameter int MAX_TILES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tlg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [7:0]                        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        req_type_i,
  input  logic signed [15:0]                frame_x_i,
  input  logic signed [15:0]                frame_y_i,
  input  logic [13:0]                       frame_width_i,
  input  logic [13:0]                       frame_height_i,
  input  logic [7:0]                        view_count_i,
  input  logic [4:0]                        max_views_i,
  input  logic                              center_first_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [3:0]                        tile_index_o,
  output logic signed [15:0]                tile_x_o,
  output logic signed [15:0]                tile_y_o,
  output logic signed [15:0]                tile_width_o,
  output logic signed [15:0]                tile_height_o,
  output logic                              tile_center_o,
  output logic                              last_tile_o
);

  localparam int CW    = $clog2(MAX_TILES + 1);
  localparam int MAG_W = (CW + 10 > 15) ? CW + 10 : 15;
  localparam int NUM_W = MAG_W + 1;
  localparam int XW    = tlg_pkg::COORD_W;
  localparam logic [7:0] MAX_N = 8'(MAX_TILES);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_SIZE = 8'b0000_0100,
    S_NUMW = 8'b0000_1000,
    S_DIVW = 8'b0001_0000,
    S_NUMH = 8'b0010_0000,
    S_DIVH = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [7:0] border_q;
  logic [7:0] gap_q;

  // Request fields.
  logic [2:0]    mode_q;
  logic [XW-1:0] fx_q;
  logic [XW-1:0] fy_q;
  logic [13:0]   fw_q;
  logic [13:0]   fh_q;
  logic          vc_nz_q;
  logic [CW-1:0] n_q;
  logic          ctr_q;
  logic          full_q;

  // Grid shape.
  logic [CW-1:0] rows_q;
  logic [CW-1:0] cols_q;
  logic [CW:0]   prod_q;

  // Sizes from the divider.
  logic [XW-1:0] w_q, rw_q, h_q, rh_q;

  // Emission walk.
  logic [CW-1:0] k_q;
  logic [CW-1:0] c_q;
  logic          first_row_q;
  logic [XW-1:0] x_q, y_q;

  // Output register.
  logic          out_valid_q;
  logic [3:0]    o_idx_q;
  logic [XW-1:0] o_x_q, o_y_q, o_w_q, o_h_q;
  logic          o_ctr_q, o_last_q;

  logic          in_fire;
  logic [7:0]    n_min, n_sat;
  logic          is_grid;
  logic          out_load;
  logic          tile_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q <= '0;
      gap_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlg_pkg::REG_BORDER_WIDTH: border_q <= cfg_data_i;
        tlg_pkg::REG_TILE_GAP:     gap_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_grid    = (mode_q == tlg_pkg::MODE_GRID);

  assign n_min = (view_count_i < {3'b000, max_views_i}) ? view_count_i
                                                        : {3'b000, max_views_i};
  assign n_sat = (n_min > MAX_N) ? MAX_N : n_min;

  // Divider numerator: length minus borders and gaps for d columns, rows or tiles.
  logic [8:0]       border2;
  logic [XW-1:0]    gb16;
  logic             use_h;
  logic [CW-1:0]    num_d, num_dm1, num_bd;
  logic [13:0]      num_len;
  logic [CW+8:0]    bmul;
  logic [CW+7:0]    gmul;
  logic [NUM_W-1:0] num;
  logic             div_start;
  logic [NUM_W-1:0] div_quo, div_rem;
  logic             div_done;

  assign border2 = {border_q, 1'b0};
  assign gb16    = XW'(border2) + XW'(gap_q);
  assign use_h   = (state_q == S_NUMH) || (mode_q == tlg_pkg::MODE_STACK);
  assign num_d   = !is_grid ? n_q : ((state_q == S_NUMH) ? rows_q : cols_q);
  assign num_dm1 = num_d - CW'(1);
  assign num_bd  = is_grid ? num_d : num_dm1;
  assign num_len = use_h ? fh_q : fw_q;
  assign bmul    = border2 * num_bd;
  assign gmul    = gap_q * num_dm1;
  assign num     = NUM_W'(num_len) - NUM_W'(bmul) - NUM_W'(gmul);

  assign div_start = (state_q == S_NUMW) || (state_q == S_NUMH);

  tlg_div #(
    .NUM_W(NUM_W),
    .DEN_W(CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (num_d),
    .quo_o  (div_quo),
    .rem_o  (div_rem),
    .done_o (div_done)
  );

  // Current tile.
  logic          first_a;
  logic [XW-1:0] size_a, size_b;
  logic [XW-1:0] fw16, fh16;
  logic [XW-1:0] t_x, t_y, t_w, t_h;
  logic [XW-1:0] x_adv, y_adv;
  logic [CW-1:0] cols_m1, n_m1;
  logic [CW+3:0] k_ext;

  assign fw16    = XW'(fw_q);
  assign fh16    = XW'(fh_q);
  assign first_a = is_grid ? (c_q == '0) : (k_q == '0);
  assign size_a  = first_a ? (w_q + rw_q) : w_q;
  assign size_b  = first_row_q ? (h_q + rh_q) : h_q;
  assign x_adv   = x_q + gb16 + size_a;
  assign y_adv   = y_q + gb16 + (is_grid ? size_b : size_a);
  assign cols_m1 = cols_q - CW'(1);
  assign n_m1    = n_q - CW'(1);
  assign k_ext   = {4'b0000, k_q};
  assign tile_last = (k_q == n_m1);

  always_comb begin
    t_x = fx_q;
    t_y = fy_q;
    t_w = fw16;
    t_h = fh16;
    if (!full_q) begin
      case (mode_q)
        tlg_pkg::MODE_GRID: begin
          t_x = x_q;
          t_y = y_q;
          t_w = size_a;
          t_h = size_b;
        end
        tlg_pkg::MODE_QUEUE: begin
          t_x = x_q;
          t_w = size_a;
        end
        default: begin
          t_y = y_q;
          t_h = size_a;
        end
      endcase
    end
  end

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_PREP;
      S_PREP: begin
        unique case (mode_q) inside
          tlg_pkg::MODE_SINGLE: state_d = vc_nz_q ? S_EMIT : S_IDLE;
          tlg_pkg::MODE_GRID, tlg_pkg::MODE_QUEUE, tlg_pkg::MODE_STACK: begin
            if (n_q == '0) begin
              state_d = S_IDLE;
            end else if (n_q == CW'(1)) begin
              state_d = S_EMIT;
            end else begin
              state_d = is_grid ? S_SIZE : S_NUMW;
            end
          end
          tlg_pkg::MODE_FULL: state_d = (n_q == '0) ? S_IDLE : S_EMIT;
          default: state_d = S_IDLE;
        endcase
      end
      S_SIZE: if (prod_q >= {1'b0, n_q}) state_d = S_NUMW;
      S_NUMW: state_d = S_DIVW;
      S_DIVW: if (div_done) state_d = is_grid ? S_NUMH : S_EMIT;
      S_NUMH: state_d = S_DIVH;
      S_DIVH: if (div_done) state_d = S_EMIT;
      S_EMIT: if (out_load && tile_last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= req_type_i;
      fx_q    <= frame_x_i;
      fy_q    <= frame_y_i;
      fw_q    <= frame_width_i;
      fh_q    <= frame_height_i;
      vc_nz_q <= (view_count_i != '0);
      n_q     <= n_sat[CW-1:0];
      ctr_q   <= center_first_i;
    end
    if (state_q == S_PREP) begin
      // A single view, or a full-frame layout, repeats the frame itself.
      full_q      <= (mode_q == tlg_pkg::MODE_SINGLE) || (mode_q == tlg_pkg::MODE_FULL) ||
                     (n_q == CW'(1));
      rows_q      <= CW'(1);
      cols_q      <= CW'(1);
      prod_q      <= (CW+1)'(1);
      k_q         <= '0;
      c_q         <= '0;
      first_row_q <= 1'b1;
      x_q         <= fx_q;
      y_q         <= fy_q;
      if (mode_q == tlg_pkg::MODE_SINGLE) begin
        n_q <= CW'(1);
      end
    end
    if ((state_q == S_SIZE) && (prod_q < {1'b0, n_q})) begin
      if (cols_q > rows_q) begin
        rows_q <= rows_q + CW'(1);
        prod_q <= prod_q + {1'b0, cols_q};
      end else begin
        cols_q <= cols_q + CW'(1);
        prod_q <= prod_q + {1'b0, rows_q};
      end
    end
    if ((state_q == S_DIVW) && div_done) begin
      w_q  <= div_quo[XW-1:0];
      // Grid remainder also absorbs the border the outer edge does not need.
      rw_q <= is_grid ? (div_rem[XW-1:0] + XW'(border2)) : div_rem[XW-1:0];
    end
    if ((state_q == S_DIVH) && div_done) begin
      h_q  <= div_quo[XW-1:0];
      rh_q <= div_rem[XW-1:0] + XW'(border2);
    end
    if (out_load) begin
      o_idx_q  <= k_ext[3:0];
      o_x_q    <= t_x;
      o_y_q    <= t_y;
      o_w_q    <= t_w;
      o_h_q    <= t_h;
      o_ctr_q  <= (k_q == '0) ? ctr_q : 1'b0;
      o_last_q <= tile_last;
      k_q      <= k_q + CW'(1);
      if (is_grid) begin
        if (c_q == cols_m1) begin
          c_q         <= '0;
          x_q         <= fx_q;
          y_q         <= y_adv;
          first_row_q <= 1'b0;
        end else begin
          c_q <= c_q + CW'(1);
          x_q <= x_adv;
        end
      end else if (mode_q == tlg_pkg::MODE_QUEUE) begin
        x_q <= x_adv;
      end else begin
        y_q <= y_adv;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tile_index_o  = o_idx_q;
  assign tile_x_o      = o_x_q;
  assign tile_y_o      = o_y_q;
  assign tile_width_o  = o_w_q;
  assign tile_height_o = o_h_q;
  assign tile_center_o = o_ctr_q;
  assign last_tile_o   = o_last_q;

endmodule
